// File: src/kmp_pkg.sv
// kmp_pkg: shared constants, codes and handshake structs of the KMP stream matcher.
// No dependencies; used by kmp_walker and kmp_stream_matcher.
package kmp_pkg;

   // Pattern store depth and text index width
   localparam int PAT_MAX    = 32;
   localparam int POS_W      = 16;

   localparam int LEN_W      = $clog2(PAT_MAX + 1);
   localparam int IDX_W      = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
   localparam int POS_FULL_W = POS_W + 1;
   localparam int SYM_W      = 8;

   // Stream payload sizes
   localparam int REQ_DATA_W = ((SYM_W + POS_W + 7) / 8) * 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_BITS   = 1 + POS_FULL_W + LEN_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request kinds (tuser bit 0)
   localparam logic CMD_PATTERN = 1'b0;
   localparam logic CMD_TEXT    = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_PAT_LONG = 2'd1;
   localparam logic [1:0] ERR_POS_OVF  = 2'd2;

   typedef struct packed {
      logic             start;
      logic             append;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] k;
      logic [SYM_W-1:0] sym;
   } walk_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] ext;
   } walk_rsp_type;

endpackage

// File: src/kmp_walker.sv
// kmp_walker: pattern store, failure table and the shared compare unit that
// follows failure links one step per cycle. Depends on kmp_pkg.
module kmp_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  kmp_pkg::walk_req_type walk_req,
   output kmp_pkg::walk_rsp_type walk_rsp
);

   typedef enum logic [1:0] {W_IDLE, W_LINK, W_CMP} walk_state_type;

   walk_state_type state_ff, state_in;
   logic [kmp_pkg::LEN_W-1:0] k_ff, k_in;
   logic [kmp_pkg::LEN_W-1:0] rd_addr;

   logic [kmp_pkg::SYM_W-1:0] store_mem [kmp_pkg::PAT_MAX];
   logic [kmp_pkg::LEN_W-1:0] fail_mem  [kmp_pkg::PAT_MAX + 1];
   logic [kmp_pkg::SYM_W-1:0] store_q_ff;
   logic [kmp_pkg::LEN_W-1:0] fail_q_ff;

   logic store_we, fail_we;
   kmp_pkg::walk_rsp_type rsp;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      rd_addr  = k_ff;
      store_we = 1'b0;
      rsp      = '0;
      case (state_ff)
         W_IDLE: begin
            rd_addr = walk_req.append ? walk_req.len : walk_req.k;
            if (walk_req.start) begin
               if (walk_req.append) begin
                  store_we = 1'b1;
                  if (walk_req.len == '0) begin
                     rsp.done = 1'b1;
                  end else begin
                     state_in = W_LINK;
                  end
               end else begin
                  k_in     = walk_req.k;
                  state_in = W_CMP;
               end
            end
         end
         W_LINK: begin
            // fetched link of the current prefix length; walk from there
            rd_addr  = fail_q_ff;
            k_in     = fail_q_ff;
            state_in = W_CMP;
         end
         W_CMP: begin
            rd_addr = fail_q_ff;
            if (k_ff >= walk_req.len) begin
               rsp.done = 1'b1;
            end else if (store_q_ff == walk_req.sym) begin
               rsp.done = 1'b1;
               rsp.ext  = k_ff + kmp_pkg::LEN_W'(1);
            end else if (k_ff == '0) begin
               rsp.done = 1'b1;
            end else begin
               k_in = fail_q_ff;
            end
            if (rsp.done) begin
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
      fail_we = rsp.done && walk_req.append;
   end

   assign walk_rsp = rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      k_ff <= k_in;
   end

   // single-port style stores, registered read
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[walk_req.len[kmp_pkg::IDX_W-1:0]] <= walk_req.sym;
      end
      if (fail_we) begin
         fail_mem[walk_req.len + kmp_pkg::LEN_W'(1)] <= rsp.ext;
      end
      store_q_ff <= store_mem[rd_addr[kmp_pkg::IDX_W-1:0]];
      fail_q_ff  <= fail_mem[rd_addr];
   end

   a_cmp_in_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == W_CMP) |-> (k_ff < walk_req.len))
      else $error("walk index left the loaded prefix");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      walk_req.start |-> (state_ff == W_IDLE))
      else $error("walk started while busy");

endmodule

// File: src/kmp_stream_matcher.sv
// kmp_stream_matcher: top level of the streaming Knuth-Morris-Pratt matcher.
// Depends on kmp_pkg and kmp_walker.
//
// Usage: load the pattern with tuser[0]=0 requests (tuser[1]=1 clears the old
// pattern first), then stream text with tuser[0]=1 (tuser[1]=1 restarts at
// start_index). Each request returns one response carrying the first match
// position (1-based, 0 while none), the loaded pattern length and an error
// code for that request only. Once a match is seen or tlast has been taken,
// text is ignored until a restart or a pattern byte. The block handles one
// request at a time: a request that needs no walk (pattern full, closed
// search, position overflow, empty pattern) goes straight to the response
// state, while any other text or pattern byte first passes through the walk
// state. The walker has a single compare unit and registered-read pattern
// and failure memories, and follows one link per cycle. A finished response
// sits in an output register, so the next request is taken while it waits.
module kmp_stream_matcher (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kmp_pkg::REQ_DATA_W-1:0]  req_tdata,  // symbol[7:0], start_index[23:8]
   input  logic [kmp_pkg::REQ_USER_W-1:0]  req_tuser,  // cmd[0], first[1]
   input  logic                            req_tlast,  // last text byte
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kmp_pkg::RSP_DATA_W-1:0]  rsp_tdata   // match_found[0], match_pos[17:1],
                                                       // pattern_len[23:18], error_code[25:24]
);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_RESP} top_state_type;

   top_state_type state_ff, state_in;

   // matcher state
   logic [kmp_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [kmp_pkg::LEN_W-1:0]      matched_ff, matched_in;
   logic [kmp_pkg::POS_FULL_W-1:0] pos_ff, pos_in;
   logic                           closed_ff, closed_in;
   logic [kmp_pkg::POS_FULL_W-1:0] found_ff, found_in;
   logic [1:0]                     err_ff, err_in;

   // walker handshake
   kmp_pkg::walk_req_type walk_req_ff, walk_req_in;
   kmp_pkg::walk_rsp_type walk_rsp;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [kmp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request decode
   logic                           cmd_bit, first_bit;
   logic [kmp_pkg::SYM_W-1:0]      sym;
   logic [kmp_pkg::POS_W-1:0]      start_idx;
   logic [kmp_pkg::LEN_W-1:0]      len_eff, matched_eff;
   logic [kmp_pkg::POS_FULL_W-1:0] pos_eff;
   logic                           closed_eff;

   assign cmd_bit   = req_tuser[0];
   assign first_bit = req_tuser[1];
   assign sym       = req_tdata[kmp_pkg::SYM_W-1:0];
   assign start_idx = req_tdata[kmp_pkg::SYM_W +: kmp_pkg::POS_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   kmp_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .walk_req (walk_req_ff),
      .walk_rsp (walk_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      matched_in   = matched_ff;
      pos_in       = pos_ff;
      closed_in    = closed_ff;
      found_in     = found_ff;
      err_in       = err_ff;
      walk_req_in  = walk_req_ff;
      walk_req_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      len_eff     = first_bit ? '0 : len_ff;
      pos_eff     = first_bit ? kmp_pkg::POS_FULL_W'(start_idx) : pos_ff;
      matched_eff = first_bit ? '0 : matched_ff;
      closed_eff  = first_bit ? 1'b0 : closed_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               err_in = kmp_pkg::ERR_NONE;
               if (cmd_bit == kmp_pkg::CMD_PATTERN) begin
                  // any pattern byte reopens the search
                  len_in     = len_eff;
                  matched_in = '0;
                  closed_in  = 1'b0;
                  found_in   = '0;
                  if (len_eff >= kmp_pkg::LEN_W'(kmp_pkg::PAT_MAX)) begin
                     err_in   = kmp_pkg::ERR_PAT_LONG;
                     state_in = S_RESP;
                  end else begin
                     walk_req_in.start  = 1'b1;
                     walk_req_in.append = 1'b1;
                     walk_req_in.len    = len_eff;
                     walk_req_in.k      = '0;
                     walk_req_in.sym    = sym;
                     state_in           = S_WALK;
                  end
               end else begin
                  pos_in     = pos_eff;
                  matched_in = matched_eff;
                  closed_in  = closed_eff;
                  if (first_bit) begin
                     found_in = '0;
                  end
                  state_in = S_RESP;
                  if (!closed_eff) begin
                     if (pos_eff[kmp_pkg::POS_W]) begin
                        // position saturated at the top of the range
                        err_in = kmp_pkg::ERR_POS_OVF;
                     end else if (len_ff == '0) begin
                        found_in  = pos_eff + kmp_pkg::POS_FULL_W'(1);
                        closed_in = 1'b1;
                     end else begin
                        walk_req_in.start  = 1'b1;
                        walk_req_in.append = 1'b0;
                        walk_req_in.len    = len_ff;
                        walk_req_in.k      = matched_eff;
                        walk_req_in.sym    = sym;
                        state_in           = S_WALK;
                     end
                  end
                  // last byte closes the search once it is handled
                  if (req_tlast) begin
                     closed_in = 1'b1;
                  end
               end
            end
         end
         S_WALK: begin
            if (walk_rsp.done) begin
               state_in = S_RESP;
               if (walk_req_ff.append) begin
                  len_in = walk_req_ff.len + kmp_pkg::LEN_W'(1);
               end else begin
                  pos_in = pos_ff + kmp_pkg::POS_FULL_W'(1);
                  if (walk_rsp.ext >= len_ff) begin
                     // full match: start = new position - length + 1
                     found_in   = pos_ff + kmp_pkg::POS_FULL_W'(2)
                                  - kmp_pkg::POS_FULL_W'(len_ff);
                     closed_in  = 1'b1;
                     matched_in = '0;
                  end else begin
                     matched_in = walk_rsp.ext;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = kmp_pkg::RSP_DATA_W'({err_ff, len_ff, found_ff,
                                                    (found_ff != '0)});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         closed_ff    <= 1'b0;
         found_ff     <= '0;
         walk_req_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         closed_ff    <= closed_in;
         found_ff     <= found_in;
         walk_req_ff  <= walk_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_rsp.done |-> (state_ff == S_WALK))
      else $error("walker finished outside a walk");

   a_matched_below_len: assert property (@(posedge clock) disable iff (reset)
      (matched_ff == '0) || (matched_ff < len_ff))
      else $error("match length not below pattern length");

   a_found_closes: assert property (@(posedge clock) disable iff (reset)
      (found_ff != '0) |-> closed_ff)
      else $error("match recorded with search still open");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= kmp_pkg::LEN_W'(kmp_pkg::PAT_MAX))
      else $error("pattern length beyond store");

endmodule

// File: tb/kmp_stream_matcher_test.sv
// kmp_stream_matcher_test: self-checking testbench for the streaming KMP matcher.
// Drives pattern and text requests, predicts every response in step with the block.
// Depends on kmp_pkg and the kmp_stream_matcher RTL.
module kmp_stream_matcher_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 60;
   localparam int POS_LIMIT    = 1 << kmp_pkg::POS_W;

   // response field offsets in rsp_tdata
   localparam int POS_LSB = 1;
   localparam int LEN_LSB = POS_LSB + kmp_pkg::POS_FULL_W;
   localparam int ERR_LSB = LEN_LSB + kmp_pkg::LEN_W;

   typedef struct packed {
      logic                      cmd;
      logic                      first;
      logic                      last;
      logic [kmp_pkg::SYM_W-1:0] sym;
      logic [kmp_pkg::POS_W-1:0] start;
   } kmp_request_type;

   typedef struct packed {
      logic                           found;
      logic [kmp_pkg::POS_FULL_W-1:0] pos;
      logic [kmp_pkg::LEN_W-1:0]      len;
      logic [1:0]                     err;
   } match_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [kmp_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [kmp_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [kmp_pkg::RSP_DATA_W-1:0] rsp_tdata;

   kmp_stream_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // request queue, expected responses and bookkeeping
   kmp_request_type  pending_requests[$];
   match_result_type expected_matches[$];
   kmp_request_type  next_req;
   bit               req_taken = 1'b0;
   int               pushed_total = 0;
   int               accepted_count = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               tx_idle_pct = 0;
   int               rx_idle_pct = 0;
   bit               hold_armed = 1'b0;
   bit               hold_taken = 1'b0;
   int               hold_left = 0;

   // generator's copy of the pattern it loaded last (for planting matches)
   logic [kmp_pkg::SYM_W-1:0] loaded_pattern[$];

   // predictor state: pattern, failure links, search progress
   logic [kmp_pkg::SYM_W-1:0] pat_mem [kmp_pkg::PAT_MAX];
   logic [kmp_pkg::LEN_W-1:0] fail_mem [kmp_pkg::PAT_MAX+1];
   int                        pat_len;
   int                        match_len;
   int                        text_pos;
   bit                        search_done;
   int                        first_hit;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // failure link of prefix length k; -1 for the empty prefix or out of range
   function automatic int link_at(input int k);
      if (k <= 0 || k > kmp_pkg::PAT_MAX) return -1;
      return int'(fail_mem[k]);
   endfunction

   // walk links until prefix k extends with c, within the first plen bytes
   function automatic int follow_links(input int k, input logic [kmp_pkg::SYM_W-1:0] c,
                                       input int plen);
      while (k >= 0 && k < kmp_pkg::PAT_MAX && k < plen && pat_mem[k] != c)
         k = link_at(k);
      if (k >= plen || k >= kmp_pkg::PAT_MAX) k = -1;
      return k;
   endfunction

   task automatic predict_match(input kmp_request_type rq, output match_result_type rs);
      int         j;
      int         len_now;
      logic [1:0] err;
      err = kmp_pkg::ERR_NONE;
      if (rq.cmd == kmp_pkg::CMD_PATTERN) begin
         // any pattern byte reopens the search; text position is kept
         if (rq.first) pat_len = 0;
         match_len = 0;
         search_done = 1'b0;
         first_hit = 0;
         if (pat_len >= kmp_pkg::PAT_MAX) begin
            err = kmp_pkg::ERR_PAT_LONG;
         end else begin
            len_now = pat_len;
            pat_mem[len_now] = rq.sym;
            j = link_at(len_now);
            if (j >= 0) j = follow_links(j, rq.sym, len_now);
            fail_mem[len_now+1] = kmp_pkg::LEN_W'(j + 1);
            pat_len = len_now + 1;
         end
      end else begin
         if (rq.first) begin
            text_pos = int'(rq.start);
            match_len = 0;
            search_done = 1'b0;
            first_hit = 0;
         end
         if (!search_done) begin
            if (text_pos >= POS_LIMIT) begin
               // position saturates, byte dropped
               text_pos = POS_LIMIT;
               err = kmp_pkg::ERR_POS_OVF;
            end else if (pat_len == 0) begin
               // empty pattern matches right here
               first_hit = text_pos + 1;
               search_done = 1'b1;
            end else begin
               j = follow_links(match_len, rq.sym, pat_len) + 1;
               text_pos++;
               if (j >= pat_len) begin
                  first_hit = text_pos - pat_len + 1;
                  search_done = 1'b1;
                  j = 0;
               end
               match_len = j;
            end
         end
         if (rq.last) search_done = 1'b1;
      end
      rs.found = (first_hit != 0);
      rs.pos   = first_hit[kmp_pkg::POS_FULL_W-1:0];
      rs.len   = pat_len[kmp_pkg::LEN_W-1:0];
      rs.err   = err;
   endtask

   task automatic push_req(input logic cmd, input logic first, input logic last,
                           input logic [kmp_pkg::SYM_W-1:0] sym,
                           input logic [kmp_pkg::POS_W-1:0] start);
      kmp_request_type rq;
      rq.cmd   = cmd;
      rq.first = first;
      rq.last  = last;
      rq.sym   = sym;
      rq.start = start;
      pending_requests.push_back(rq);
      pushed_total++;
   endtask

   // Random traffic: mostly a pattern load followed by a text run drawn from a
   // small alphabet with planted copies of the pattern, plus restarts on the
   // kept pattern and some fully random noise.
   task automatic gen_random(input int quota, input bit long_first);
      int                        made;
      int                        kind;
      int                        n;
      int                        i;
      int                        run_len;
      int                        plant_at;
      int                        alpha_n;
      bit                        force_long;
      bit                        extend;
      bit                        close_run;
      logic                      first_bit;
      logic [kmp_pkg::SYM_W-1:0] alpha [3];
      logic [kmp_pkg::SYM_W-1:0] sym;
      logic [kmp_pkg::POS_W-1:0] st;
      made = 0;
      force_long = long_first;
      while (made < quota) begin
         alpha_n = $urandom_range(2, 3);
         for (i = 0; i < 3; i++) alpha[i] = kmp_pkg::SYM_W'($urandom_range(0, 255));
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            if (force_long) n = kmp_pkg::PAT_MAX + 2;
            else if ($urandom_range(0, 11) == 0)
               n = $urandom_range(kmp_pkg::PAT_MAX - 2, kmp_pkg::PAT_MAX + 2);
            else n = $urandom_range(1, 6);
            force_long = 1'b0;
            extend = ($urandom_range(0, 5) == 0);
            if (!extend) loaded_pattern.delete();
            for (i = 0; i < n; i++) begin
               sym = alpha[$urandom_range(0, alpha_n - 1)];
               // tlast on a pattern request means nothing; toggle it anyway
               push_req(kmp_pkg::CMD_PATTERN, (i == 0) && !extend, 1'($urandom_range(0, 1)),
                        sym, kmp_pkg::POS_W'($urandom_range(0, 65535)));
               if (loaded_pattern.size() < kmp_pkg::PAT_MAX) loaded_pattern.push_back(sym);
            end
            made += n;
         end
         if (kind <= 8) begin
            run_len = $urandom_range(1, 12 + loaded_pattern.size());
            if ($urandom_range(0, 4) == 0)
               st = kmp_pkg::POS_W'(16'hFFFF - $urandom_range(0, 40));
            else st = kmp_pkg::POS_W'($urandom_range(0, 65535));
            close_run = ($urandom_range(0, 3) != 0);
            first_bit = ($urandom_range(0, 5) != 0);
            plant_at = -1;
            for (i = 0; i < run_len; i++) begin
               if (plant_at < 0 && loaded_pattern.size() != 0 && $urandom_range(0, 3) == 0)
                  plant_at = 0;
               if (plant_at >= 0) begin
                  sym = loaded_pattern[plant_at];
                  plant_at++;
                  if (plant_at == loaded_pattern.size()) plant_at = -1;
               end else begin
                  sym = alpha[$urandom_range(0, alpha_n - 1)];
               end
               if ($urandom_range(0, 15) == 0) sym = kmp_pkg::SYM_W'($urandom_range(0, 255));
               push_req(kmp_pkg::CMD_TEXT, (i == 0) ? first_bit : 1'b0,
                        (i == run_len - 1) ? close_run : ($urandom_range(0, 30) == 0),
                        sym, (i == 0) ? st : kmp_pkg::POS_W'($urandom_range(0, 65535)));
            end
            made += run_len;
            // stray text after the run, usually dropped by a closed search
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++)
                  push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'($urandom_range(0, 1)),
                           kmp_pkg::SYM_W'($urandom_range(0, 255)),
                           kmp_pkg::POS_W'($urandom_range(0, 65535)));
            end
         end else begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++)
               push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), kmp_pkg::SYM_W'($urandom_range(0, 255)),
                        kmp_pkg::POS_W'($urandom_range(0, 65535)));
            made += n;
         end
      end
   endtask

   // wait until every request went in and every response came back
   task automatic wait_drain();
      while (pending_requests.size() != 0 || accepted_count != pushed_total ||
             expected_matches.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Sender: one request on the bus at a time, held until the handshake.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // still waiting for req_tready
      end else if (pending_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
         next_req = pending_requests.pop_front();
         req_tdata  <= {next_req.start, next_req.sym};
         req_tuser  <= {next_req.first, next_req.cmd};
         req_tlast  <= next_req.last;
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Receiver: random back-pressure plus one long hold-off once armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_armed && !hold_taken) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Monitor: check the response first, then predict for the request taken
   // on the same edge (its response cannot come out on this edge).
   always @(posedge clock) begin
      kmp_request_type  rq;
      match_result_type got;
      match_result_type want;
      if (reset) begin
         req_taken   = 1'b0;
         pat_len     = 0;
         match_len   = 0;
         text_pos    = 0;
         search_done = 1'b0;
         first_hit   = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tdata[0];
            got.pos   = rsp_tdata[POS_LSB +: kmp_pkg::POS_FULL_W];
            got.len   = rsp_tdata[LEN_LSB +: kmp_pkg::LEN_W];
            got.err   = rsp_tdata[ERR_LSB +: 2];
            if (expected_matches.size() == 0) begin
               report_mismatch("unexpected response", longint'(rsp_tdata), 0);
            end else begin
               want = expected_matches.pop_front();
               if (got.found !== want.found)
                  report_mismatch("match_found", longint'(got.found), longint'(want.found));
               if (got.pos !== want.pos)
                  report_mismatch("match_pos", longint'(got.pos), longint'(want.pos));
               if (got.len !== want.len)
                  report_mismatch("pattern_len", longint'(got.len), longint'(want.len));
               if (got.err !== want.err)
                  report_mismatch("error_code", longint'(got.err), longint'(want.err));
               if (rsp_tdata[kmp_pkg::RSP_DATA_W-1:kmp_pkg::RSP_BITS] !== '0)
                  report_mismatch("padding",
                                  longint'(rsp_tdata[kmp_pkg::RSP_DATA_W-1:kmp_pkg::RSP_BITS]),
                                  0);
            end
         end
         if (req_taken) begin
            rq.cmd   = req_tuser[0];
            rq.first = req_tuser[1];
            rq.last  = req_tlast;
            rq.sym   = req_tdata[kmp_pkg::SYM_W-1:0];
            rq.start = req_tdata[kmp_pkg::SYM_W +: kmp_pkg::POS_W];
            predict_match(rq, want);
            expected_matches.push_back(want);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      tx_idle_pct = 10;
      rx_idle_pct = 76;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // empty pattern after reset: hit at start_index+1, then closed
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h00, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hFF, 16'hFFFF);
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b1, 8'hAA, 16'hFFFF);
      // pattern "ABA"; tlast on pattern requests is ignored
      push_req(kmp_pkg::CMD_PATTERN, 1'b1, 1'b1, 8'h41, 16'hFFFF);
      push_req(kmp_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'h42, 16'h0000);
      push_req(kmp_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'h41, 16'h5A5A);
      // "ABBABAA": partial match falls back along the links, then hits
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h41, 16'h1234);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h42, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h42, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h42, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41, 16'h0000);
      // run off the top of the text index: saturate and flag
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h00, 16'hFFFE);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hFF, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h41, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h41, 16'h0000);
      // hit that ends exactly at the last valid index
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b0, 8'h41, 16'hFFFD);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h42, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b1, 8'h41, 16'h0000);
      // all-ones pattern against all-zero/all-one text
      push_req(kmp_pkg::CMD_PATTERN, 1'b1, 1'b0, 8'hFF, 16'h0000);
      push_req(kmp_pkg::CMD_PATTERN, 1'b0, 1'b0, 8'hFF, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b1, 1'b0, 8'hFF, 16'h00FF);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'h00, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b0, 8'hFF, 16'h0000);
      push_req(kmp_pkg::CMD_TEXT, 1'b0, 1'b1, 8'hFF, 16'h0000);
      wait_drain();

      // first random set opens with an over-long pattern load
      gen_random(250, 1'b1);
      wait_drain();

      tx_idle_pct = 76;
      rx_idle_pct = 10;
      gen_random(250, 1'b0);
      wait_drain();

      // no idling; receiver holds off a long while so the input backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_armed  = 1'b1;
      gen_random(200, 1'b0);
      wait_drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_matches.size() != 0)
         report_mismatch("missing responses", 0, longint'(expected_matches.size()));
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: kmp_stream_matcher.f
src/kmp_pkg.sv
src/kmp_walker.sv
src/kmp_stream_matcher.sv
tb/kmp_stream_matcher_test.sv
